@@ sv/urxrb_pkg.sv @@
// ----------------------------------------------------------------------------
// urxrb_pkg
// Shared types and constants for the 8N1 receiver with receive ring buffer.
// ----------------------------------------------------------------------------
package urxrb_pkg;

  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam logic [15:0] BIT_TICKS_RST  = 16'd104;

  // request kinds
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // receive events
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_STORED      = 3'd1;
  localparam logic [2:0] EV_DROPPED     = 3'd2;
  localparam logic [2:0] EV_BAD_STOP    = 3'd3;
  localparam logic [2:0] EV_FALSE_START = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_STOP  = 4'b1000
  } rx_phase_t;

  // what the frame receiver reports for one tick
  typedef struct packed {
    logic       stop_ok;
    logic       bad_stop;
    logic       false_start;
    logic [7:0] rx_byte;
  } rx_res_t;

endpackage

@@ sv/urxrb_ram.sv @@
// ----------------------------------------------------------------------------
// urxrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module urxrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/urxrb_frame.sv @@
// ----------------------------------------------------------------------------
// urxrb_frame
// 8N1 frame receiver: start detect, half-bit recheck, eight data bits, stop.
// ----------------------------------------------------------------------------
module urxrb_frame
  import urxrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic        level,
  input  logic [15:0] bit_ticks,
  output rx_res_t     res
);

  rx_phase_t   phase, phase_next;
  logic [15:0] countdown, countdown_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [3:0]  bits_taken, bits_taken_next;
  logic        prev_level, prev_level_next;

  logic [15:0] period_full, period_half, dec;
  logic [3:0]  bits_inc;

  always_comb begin
    period_full = (bit_ticks == 16'd0) ? 16'd1 : bit_ticks;
    period_half = (bit_ticks[15:1] == 15'd0) ? 16'd1 : {1'b0, bit_ticks[15:1]};
    dec         = countdown - 16'd1;
    bits_inc    = bits_taken + 4'd1;

    phase_next      = phase;
    countdown_next  = countdown;
    shift_byte_next = shift_byte;
    bits_taken_next = bits_taken;
    prev_level_next = prev_level;
    res             = '0;
    res.rx_byte     = shift_byte;

    if (tick) begin
      prev_level_next = level;
      case (phase)
        PH_IDLE: begin
          if (prev_level && !level) begin
            phase_next     = PH_START;
            countdown_next = period_half;
          end
        end
        PH_START: begin
          countdown_next = dec;
          if (dec == 16'd0) begin
            if (!level) begin
              shift_byte_next = 8'd0;
              bits_taken_next = 4'd0;
              phase_next      = PH_DATA;
              countdown_next  = period_full;
            end else begin
              phase_next      = PH_IDLE;
              res.false_start = 1'b1;
            end
          end
        end
        PH_DATA: begin
          countdown_next = dec;
          if (dec == 16'd0) begin
            shift_byte_next = {level, shift_byte[7:1]};
            bits_taken_next = bits_inc;
            if (bits_inc[3]) begin
              phase_next = PH_STOP;
            end
            countdown_next = period_full;
          end
        end
        PH_STOP: begin
          countdown_next = dec;
          if (dec == 16'd0) begin
            res.stop_ok  = level;
            res.bad_stop = !level;
            phase_next   = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      countdown  <= 16'd0;
      shift_byte <= 8'd0;
      bits_taken <= 4'd0;
      prev_level <= 1'b1;
    end else begin
      phase      <= phase_next;
      countdown  <= countdown_next;
      shift_byte <= shift_byte_next;
      bits_taken <= bits_taken_next;
      prev_level <= prev_level_next;
    end
  end

endmodule

@@ sv/uart_rx_with_ring_buffer_core.sv @@
// ----------------------------------------------------------------------------
// uart_rx_with_ring_buffer_core
// 8N1 serial receiver fed by line samples, with a receive ring buffer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser opcode, tdata line_level
//  m_axis    out  m_axis_tvalid/tready       tuser read_valid, tdata result
//  cfg       in   cfg_wr_en                  cfg_wr_data = bit_ticks
//
// one request per clock unless m_axis stalls; input register, result register
// ring reads come from a registered-read ram that is prefetched at the next
// read index, with a bypass for a byte written at that same index
// rst is synchronous; ring contents are not cleared, indices reset to zero
// a stalled result holds in the output register, one more request waits in
// the input register, then s_axis_tready drops
// ----------------------------------------------------------------------------
module uart_rx_with_ring_buffer_core
  import urxrb_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] line_level, [7:1] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] read_data, [15:8] bytes_available,
                                      // [18:16] rx_event, [23:19] zero
  output logic        m_axis_tuser,   // [0] read_valid
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = (AW + 1 > 9) ? AW + 1 : 9;

  logic [15:0] bit_ticks;

  // input register
  logic       s1_valid;
  logic [1:0] s1_op;
  logic       s1_level;

  logic advance, fire, tick;
  rx_res_t rx_res;

  logic [AW-1:0] wr_idx, rd_idx, wr_idx_next, rd_idx_next, rd_addr;
  logic [AW-1:0] wr_inc, rd_inc;
  logic          ram_we;
  logic [7:0]    ram_q, head_byte, byp_data;
  logic          byp_valid;

  logic [7:0]    res_data, res_avail;
  logic          res_valid;
  logic [2:0]    res_event;
  logic [CW-1:0] cnt_wide;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign fire          = s1_valid && advance;
  assign s_axis_tready = !s1_valid || advance;
  assign tick          = fire && (s1_op == OP_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks <= BIT_TICKS_RST;
    end else if (cfg_wr_en) begin
      bit_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      s1_op    <= s_axis_tuser;
      s1_level <= s_axis_tdata[0];
    end
  end

  urxrb_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .level     (s1_level),
    .bit_ticks (bit_ticks),
    .res       (rx_res)
  );

  assign wr_inc = (wr_idx == AW'(RING_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
  assign rd_inc = (rd_idx == AW'(RING_DEPTH - 1)) ? '0 : rd_idx + 1'b1;

  // byte at the read index, newest write wins
  assign head_byte = byp_valid ? byp_data : ram_q;

  always_comb begin
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    ram_we      = 1'b0;
    res_data    = 8'd0;
    res_valid   = 1'b0;
    res_event   = EV_NONE;
    case (s1_op)
      OP_TICK: begin
        if (rx_res.stop_ok) begin
          if (wr_inc != rd_idx) begin
            ram_we      = fire;
            wr_idx_next = wr_inc;
            res_event   = EV_STORED;
          end else begin
            res_event = EV_DROPPED;
          end
        end else if (rx_res.bad_stop) begin
          res_event = EV_BAD_STOP;
        end else if (rx_res.false_start) begin
          res_event = EV_FALSE_START;
        end
      end
      OP_READ: begin
        if (wr_idx != rd_idx) begin
          res_data    = head_byte;
          res_valid   = 1'b1;
          rd_idx_next = rd_inc;
        end
      end
      OP_FLUSH: begin
        wr_idx_next = '0;
        rd_idx_next = '0;
      end
      default: begin
      end
    endcase

    if (wr_idx_next >= rd_idx_next) begin
      cnt_wide = CW'(wr_idx_next) - CW'(rd_idx_next);
    end else begin
      cnt_wide = CW'(RING_DEPTH) - CW'(rd_idx_next) + CW'(wr_idx_next);
    end
    res_avail = (cnt_wide > CW'(255)) ? 8'hFF : cnt_wide[7:0];
  end

  assign rd_addr = fire ? rd_idx_next : rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
    end else if (fire) begin
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
    end
  end

  urxrb_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (rx_res.rx_byte),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= ram_we && (wr_idx == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= rx_res.rx_byte;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {5'd0, res_event, res_avail, res_data};
      m_axis_tuser <= res_valid;
    end
  end

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_wide <= CW'(RING_DEPTH - 1))
    else $error("ring fill exceeds depth minus one");

  a_read_no_event: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[18:16] == EV_NONE)
    else $error("read result carries a receive event");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
    else $error("read data nonzero without a popped byte");

  a_write_on_tick: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> fire && (s1_op == OP_TICK) && rx_res.stop_ok)
    else $error("ring write outside a good stop bit");

endmodule

@@ bench/tb_uart_rx_with_ring_buffer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_rx_with_ring_buffer_core
// Self-checking bench for the 8N1 receiver with ring buffer. Tick, read, flush
// and unused requests are streamed in. Every request yields one result, each
// checked against a bit-true software copy of the receiver and its ring or a
// directed row's typed result. The run has a directed table, random frames at
// several bit periods, a partial ring fill and drain, and a long output stall.
// ----------------------------------------------------------------------------
module tb_uart_rx_with_ring_buffer_core;
  import urxrb_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         HOLD_LEN       = 400;
  localparam int         MAX_REPORTS    = 40;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       rd_valid;
    logic [7:0] avail;
    logic [2:0] rx_ev;
  } rx_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  op;
    logic        lvl;
    logic [15:0] cfg;
    bit          typed;
    rx_out_t     res;
  } stim_row_t;

  localparam rx_out_t RES_QUIET    = '{8'd0,   1'b0, 8'd0, EV_NONE};
  localparam rx_out_t RES_FALSE    = '{8'd0,   1'b0, 8'd0, EV_FALSE_START};
  localparam rx_out_t RES_STORED   = '{8'd0,   1'b0, 8'd1, EV_STORED};
  localparam rx_out_t RES_READ_FF  = '{8'hFF,  1'b1, 8'd0, EV_NONE};
  localparam rx_out_t RES_BAD_STOP = '{8'd0,   1'b0, 8'd0, EV_BAD_STOP};

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [0] line_level, [7:1] zero
  logic [1:0]  s_axis_tuser  = OP_TICK; // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [7:0] read_data, [15:8] bytes_available,
                                       // [18:16] rx_event, [23:19] zero
  logic        m_axis_tuser;           // [0] read_valid
  logic        cfg_wr_en     = 1'b0;
  logic [15:0] cfg_wr_data   = 16'd0;

  // software copy of the receiver and ring
  logic [15:0] model_ticks = BIT_TICKS_RST;
  rx_phase_t   model_phase = PH_IDLE;
  logic [15:0] model_count = 16'd0;
  logic [7:0]  model_shift = 8'd0;
  logic [3:0]  model_nbits = 4'd0;
  logic        model_prev  = 1'b1;
  logic [7:0]  ring_mem [0:255];
  logic [7:0]  ring_wr = 8'd0;
  logic [7:0]  ring_rd = 8'd0;

  rx_out_t     rx_results_due [$];
  stim_row_t   dir_rows [$];
  int          items_sent     = 0;
  int          err_count      = 0;
  int          stall_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  bit          long_period    = 1'b0;
  bit          frame_reads_on = 1'b1;
  logic        hold_kick      = 1'b0;
  logic        hold_seen      = 1'b0;
  int          hold_left      = 0;

  uart_rx_with_ring_buffer_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic predict_rx_result(input logic [1:0] op, input logic lvl,
                                   output rx_out_t r);
    logic [15:0] full_p;
    logic [15:0] half_p;
    logic [7:0]  nxt;
    r      = '0;
    full_p = (model_ticks == 16'd0) ? 16'd1 : model_ticks;
    half_p = ((model_ticks >> 1) == 16'd0) ? 16'd1 : (model_ticks >> 1);
    if (op == OP_TICK) begin
      if (model_phase == PH_IDLE) begin
        if (model_prev && !lvl) begin
          model_phase = PH_START;
          model_count = half_p;
        end
      end else begin
        model_count = model_count - 16'd1;
        if (model_count == 16'd0) begin
          if (model_phase == PH_START) begin
            if (!lvl) begin
              model_shift = 8'd0;
              model_nbits = 4'd0;
              model_phase = PH_DATA;
              model_count = full_p;
            end else begin
              model_phase = PH_IDLE;
              r.rx_ev     = EV_FALSE_START;
            end
          end else if (model_phase == PH_DATA) begin
            model_shift = {lvl, model_shift[7:1]};
            model_nbits = model_nbits + 4'd1;
            if (model_nbits >= 4'd8) model_phase = PH_STOP;
            model_count = full_p;
          end else begin
            if (lvl) begin
              // one slot stays empty, so next == read means full
              nxt = ring_wr + 8'd1;
              if (nxt != ring_rd) begin
                ring_mem[ring_wr] = model_shift;
                ring_wr           = nxt;
                r.rx_ev           = EV_STORED;
              end else begin
                r.rx_ev = EV_DROPPED;
              end
            end else begin
              r.rx_ev = EV_BAD_STOP;
            end
            model_phase = PH_IDLE;
          end
        end
      end
      model_prev = lvl;
    end else if (op == OP_READ) begin
      if (ring_wr != ring_rd) begin
        r.rd_data  = ring_mem[ring_rd];
        r.rd_valid = 1'b1;
        ring_rd    = ring_rd + 8'd1;
      end
    end else if (op == OP_FLUSH) begin
      ring_wr = 8'd0;
      ring_rd = 8'd0;
    end
    r.avail = ring_wr - ring_rd;
  endtask

  task automatic send_item(input logic [1:0] op, input logic lvl,
                           input bit typed = 1'b0, input rx_out_t typed_res = '0);
    rx_out_t pred;
    // idle single cycles, each with the sender's idle chance
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, lvl};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_rx_result(op, lvl, pred);
    rx_results_due.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  task automatic wait_results_drained();
    while (rx_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_bit_ticks(input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    wait_results_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_ticks = val;
  endtask

  // high ticks until the receiver is idle with the line high
  task automatic settle_line();
    while (model_phase != PH_IDLE || model_prev != 1'b1) send_item(OP_TICK, 1'b1);
  endtask

  function automatic logic line_jitter(input logic l);
    return ($urandom_range(7) == 0) ? !l : l;
  endfunction

  task automatic frame_tick(input logic lvl);
    if (frame_reads_on && $urandom_range(24) == 0) send_item(OP_READ, 1'($urandom_range(1)));
    send_item(OP_TICK, lvl);
  endtask

  task automatic send_frame(input logic [7:0] data, input bit start_ok,
                            input logic stop_lvl);
    int unsigned full_p;
    int unsigned half_p;
    logic        lvl;
    full_p = (model_ticks == 16'd0) ? 1 : model_ticks;
    half_p = (model_ticks / 2 == 0) ? 1 : model_ticks / 2;
    settle_line();
    repeat ($urandom_range(0, 2)) frame_tick(1'b1);
    frame_tick(1'b0);
    lvl = 1'b0;
    // samples between the sampling points are don't-care, so wiggle them
    repeat (half_p - 1) frame_tick(line_jitter(lvl));
    frame_tick(!start_ok);
    if (start_ok) begin
      for (int i = 0; i < 8; i++) begin
        repeat (full_p - 1) frame_tick(line_jitter(lvl));
        lvl = data[i];
        frame_tick(lvl);
      end
      repeat (full_p - 1) frame_tick(line_jitter(lvl));
      frame_tick(stop_lvl);
    end
  endtask

  task automatic run_random(input int n);
    int          stop_at;
    int unsigned pick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        if (long_period) send_item(OP_TICK, 1'b1);
        else send_frame(8'($urandom), $urandom_range(15) != 0,
                        1'($urandom_range(11) != 0));
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) send_item(OP_READ, 1'($urandom));
      end else if (pick < 79) begin
        send_item(OP_FLUSH, 1'($urandom));
      end else if (pick < 83) begin
        send_item(OP_UNUSED, 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(OP_TICK, long_period ? 1'b1 : 1'($urandom));
      end
    end
  endtask

  // result side: random ready, long hold on request, and the compare
  always @(posedge clk) begin
    rx_out_t want;
    if (hold_kick != hold_seen) begin
      hold_seen     <= hold_kick;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rx_results_due.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_axis_tdata,
                   m_axis_tuser);
      end else begin
        want = rx_results_due.pop_front();
        if (m_axis_tdata[7:0] !== want.rd_data || m_axis_tuser !== want.rd_valid ||
            m_axis_tdata[15:8] !== want.avail || m_axis_tdata[18:16] !== want.rx_ev) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display({"%0t: mismatch exp data=%h valid=%b avail=%0d ev=%0d,",
                      " got data=%h valid=%b avail=%0d ev=%0d"},
                     $time, want.rd_data, want.rd_valid, want.avail, want.rx_ev,
                     m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[15:8],
                     m_axis_tdata[18:16]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** uart_rx_with_ring_buffer_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    dir_rows = '{
      // at reset: empty ring, unused opcode, flush
      '{ROW_ITEM, OP_READ,   1'b0, 16'd0, 1'b1, RES_QUIET},
      '{ROW_ITEM, OP_UNUSED, 1'b1, 16'd0, 1'b1, RES_QUIET},
      '{ROW_ITEM, OP_FLUSH,  1'b0, 16'd0, 1'b1, RES_QUIET},
      // zero bit period behaves as one tick per bit
      '{ROW_CFG,  OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      // false start
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b1, 16'd0, 1'b1, RES_FALSE},
      // 0xff with a good stop
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b1, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b1, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b1, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b1, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b1, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b1, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b1, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b1, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b1, 16'd0, 1'b1, RES_STORED},
      '{ROW_ITEM, OP_READ,   1'b1, 16'd0, 1'b1, RES_READ_FF},
      // 0x00 with a low stop bit
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET},
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b1, RES_BAD_STOP},
      // line still low: no fresh edge, stays idle
      '{ROW_ITEM, OP_TICK,   1'b0, 16'd0, 1'b0, RES_QUIET}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 28;
    recv_idle_pct <= 56;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_bit_ticks(dir_rows[i].cfg);
      else send_item(dir_rows[i].op, dir_rows[i].lvl, dir_rows[i].typed, dir_rows[i].res);
    end

    write_bit_ticks(16'd1);
    // long output stall while requests keep coming
    hold_kick <= !hold_kick;
    run_random(250);
    write_bit_ticks(16'd3);
    run_random(200);

    send_idle_pct = 56;
    recv_idle_pct <= 28;
    write_bit_ticks(16'd0);
    run_random(250);
    // longest period: keep the line high, a frame would take far too long
    settle_line();
    long_period = 1'b1;
    write_bit_ticks(16'hFFFF);
    run_random(100);
    long_period = 1'b0;

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_bit_ticks(16'd2);
    run_random(250);
    // fill part of the ring, then drain it and read once more when empty
    write_bit_ticks(16'd1);
    frame_reads_on = 1'b0;
    send_item(OP_FLUSH, 1'b0);
    repeat (24) send_frame(8'($urandom), 1'b1, 1'b1);
    repeat (25) send_item(OP_READ, 1'($urandom));
    frame_reads_on = 1'b1;
    write_bit_ticks(16'd5);
    run_random(300);

    s_axis_tvalid <= 1'b0;
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("** uart_rx_with_ring_buffer_core: PASSED **");
    end else begin
      $display("** uart_rx_with_ring_buffer_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/urxrb_pkg.sv
sv/urxrb_ram.sv
sv/urxrb_frame.sv
sv/uart_rx_with_ring_buffer_core.sv
bench/tb_uart_rx_with_ring_buffer_core.sv
